### rtl/core/layer_z_order_stack_assert.svh
// Assertion macros for the layer stacking-order block.
// Used by the port checker; relies on clk_i and rst_ni in the including scope.
`ifndef LAYER_Z_ORDER_STACK_ASSERT_SVH
`define LAYER_Z_ORDER_STACK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LZS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("layer_z_order_stack: check failed");

// Consequent checked in the cycle after the antecedent.
`define LZS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("layer_z_order_stack: check failed");

`endif

### rtl/core/lzs_pkg.sv
// Shared constants and types for the layer stacking-order block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lzs_pkg;

  localparam int unsigned MAX_LAYERS_DEFAULT = 256;
  localparam int unsigned ID_W               = 8;
  localparam int unsigned HEIGHT_W           = 9;
  localparam int unsigned CALC_W             = HEIGHT_W + 1;

  typedef struct packed {
    logic capture;
    logic read;
    logic apply;
  } cmd_t;

endpackage

### rtl/core/lzs_ctrl.sv
// Controller of the layer stacking-order block: sequences capture, read and apply.
// Depends on lzs_pkg for the command struct.
`timescale 1ns / 1ps

module lzs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output lzs_pkg::cmd_t cmd_o,
  output logic          result_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.read    = 1'b0;
    cmd_o.apply   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.apply;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

endmodule

### rtl/core/lzs_datapath.sv
// Datapath of the layer stacking-order block: order and height cells, clamp and shift.
// Depends on lzs_pkg for widths and the command struct.
`timescale 1ns / 1ps

module lzs_datapath #(
  parameter int unsigned MAX_LAYERS = lzs_pkg::MAX_LAYERS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lzs_pkg::cmd_t                       cmd_i,
  input  logic        [lzs_pkg::ID_W-1:0]     layer_id_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] new_height_i,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] applied_height_o,
  output logic                                changed_o,
  output logic        [lzs_pkg::ID_W-1:0]     map_from_height_o,
  output logic        [lzs_pkg::ID_W-1:0]     redraw_low_o,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] redraw_high_o,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] top_height_o
);

  localparam int unsigned IdW   = lzs_pkg::ID_W;
  localparam int unsigned HW    = lzs_pkg::HEIGHT_W;
  localparam int unsigned CW    = lzs_pkg::CALC_W;
  localparam int unsigned IdxW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam logic signed [CW-1:0] CalcNeg1   = '1;
  localparam logic signed [HW-1:0] HeightNeg1 = '1;
  localparam logic [IdW:0]         IdLimit    = (IdW + 1)'(MAX_LAYERS);

  logic        [IdW-1:0] id_q;
  logic signed [HW-1:0]  req_q;
  logic signed [HW-1:0]  old_q;
  logic signed [HW-1:0]  top_q;
  logic                  id_ok_q;

  logic signed [HW-1:0]  level_q [MAX_LAYERS];
  logic        [IdW-1:0] order_q [MAX_LAYERS];

  logic                  id_ok;
  logic signed [CW-1:0]  top_x, old_x, req_x, bound, h_cap, h;
  logic signed [CW-1:0]  h_p1, old_m1, old_p1, lo, hi;
  logic signed [HW-1:0]  top_d;
  logic                  do_lower, do_hide, do_raise, do_insert;
  logic                  shift_up, shift_dn, do_place, any_change;

  assign id_ok = ({1'b0, id_q} < IdLimit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q  <= layer_id_i;
      req_q <= new_height_i;
    end
    if (cmd_i.read) begin
      id_ok_q <= id_ok;
      old_q   <= id_ok ? level_q[id_q[IdxW-1:0]] : HeightNeg1;
    end
  end

  always_comb begin
    top_x  = CW'(top_q);
    old_x  = CW'(old_q);
    req_x  = CW'(req_q);
    bound  = old_q[HW-1] ? CW'(top_x - CalcNeg1) : top_x;
    h_cap  = (req_x > bound) ? bound : req_x;
    h      = (h_cap < CalcNeg1) ? CalcNeg1 : h_cap;
    h_p1   = CW'(h - CalcNeg1);
    old_m1 = CW'(old_x + CalcNeg1);
    old_p1 = CW'(old_x - CalcNeg1);

    do_lower  = id_ok_q && (h < old_x) && !h[CW-1];
    do_hide   = id_ok_q && (h < old_x) && h[CW-1];
    do_raise  = id_ok_q && (h > old_x) && !old_x[CW-1];
    do_insert = id_ok_q && (h > old_x) && old_x[CW-1];

    shift_up   = do_lower || do_insert;
    shift_dn   = do_hide || do_raise;
    do_place   = do_lower || do_raise || do_insert;
    any_change = shift_up || shift_dn;

    lo = shift_up ? h : old_p1;
    if (do_lower) begin
      hi = old_m1;
    end else if (do_raise) begin
      hi = h;
    end else begin
      hi = top_x;
    end

    if (do_hide) begin
      top_d = HW'(top_x + CalcNeg1);
    end else if (do_insert) begin
      top_d = HW'(top_x - CalcNeg1);
    end else begin
      top_d = top_q;
    end
  end

  for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
    localparam logic signed [CW-1:0] Pos   = CW'(g);
    localparam logic signed [CW-1:0] Below = CW'(g - 1);
    localparam logic signed [CW-1:0] Above = CW'(g + 1);
    localparam logic [IdW-1:0]       Id    = IdW'(g);

    logic [IdW-1:0]       from_below, from_above;
    logic                 take_below, take_above, lvl_in;
    logic signed [CW-1:0] lvl_x;

    if (g > 0) begin : g_below
      assign from_below = order_q[g-1];
      assign take_below = shift_up && (Below >= lo) && (Below <= hi);
    end else begin : g_no_below
      assign from_below = order_q[g];
      assign take_below = 1'b0;
    end

    if (g < MAX_LAYERS - 1) begin : g_above
      assign from_above = order_q[g+1];
      assign take_above = shift_dn && (Above >= lo) && (Above <= hi);
    end else begin : g_no_above
      assign from_above = order_q[g];
      assign take_above = 1'b0;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) begin
        if (do_place && (h == Pos)) begin
          order_q[g] <= id_q;
        end else if (take_below) begin
          order_q[g] <= from_below;
        end else if (take_above) begin
          order_q[g] <= from_above;
        end
      end
    end

    assign lvl_x  = CW'(level_q[g]);
    assign lvl_in = (lvl_x >= lo) && (lvl_x <= hi);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        level_q[g] <= HeightNeg1;
      end else if (cmd_i.apply) begin
        if (id_ok_q && (id_q == Id)) begin
          level_q[g] <= h[HW-1:0];
        end else if (shift_up && lvl_in) begin
          level_q[g] <= HW'(lvl_x - CalcNeg1);
        end else if (shift_dn && lvl_in) begin
          level_q[g] <= HW'(lvl_x + CalcNeg1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= HeightNeg1;
    end else if (cmd_i.apply) begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      applied_height_o <= id_ok_q ? h[HW-1:0] : HeightNeg1;
      changed_o        <= any_change;
      top_height_o     <= top_d;
      if (do_lower) begin
        map_from_height_o <= h_p1[IdW-1:0];
        redraw_low_o      <= h_p1[IdW-1:0];
        redraw_high_o     <= old_q;
      end else if (do_hide) begin
        map_from_height_o <= '0;
        redraw_low_o      <= '0;
        redraw_high_o     <= old_m1[HW-1:0];
      end else if (do_raise || do_insert) begin
        map_from_height_o <= h[IdW-1:0];
        redraw_low_o      <= h[IdW-1:0];
        redraw_high_o     <= h[HW-1:0];
      end else begin
        map_from_height_o <= '0;
        redraw_low_o      <= '0;
        redraw_high_o     <= HeightNeg1;
      end
    end
  end

endmodule

### rtl/core/layer_z_order_stack.sv
// Top level of the layer stacking-order block.
// Instantiates lzs_ctrl and lzs_datapath; depends on lzs_pkg.
//
// Usage: a request names a layer (layer_id_i) and a requested height
// (new_height_i, -1 hides the layer). It is transferred at a rising edge at
// which start is high and busy is low. The request is clamped, the layer is
// moved, inserted or hidden, and the layers in between shift by one.
// Exactly one result per request appears on the result ports for one cycle,
// marked by result_valid_o, once the apply step has registered it. After the
// transfer an item passes through a read step, which reads the layer's current
// height from the height cells, and then an apply step, which clamps and shifts
// every order and height cell at once. busy is high during both steps, so no
// new request is taken while one is in progress; a new request may be
// transferred at the edge that ends the cycle in which the previous result is
// shown. Results cannot be held off: the receiver must take each one when it
// is shown. Reset hides every layer and sets the top height to -1; the block
// accepts requests as soon as reset is released.
`timescale 1ns / 1ps

module layer_z_order_stack #(
  parameter int unsigned MAX_LAYERS = lzs_pkg::MAX_LAYERS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic        [lzs_pkg::ID_W-1:0]     layer_id_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] new_height_i,
  output logic                                result_valid_o,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] applied_height_o,
  output logic                                changed_o,
  output logic        [lzs_pkg::ID_W-1:0]     map_from_height_o,
  output logic        [lzs_pkg::ID_W-1:0]     redraw_low_o,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] redraw_high_o,
  output logic signed [lzs_pkg::HEIGHT_W-1:0] top_height_o
);

  lzs_pkg::cmd_t cmd;

  lzs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  lzs_datapath #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .layer_id_i        (layer_id_i),
    .new_height_i      (new_height_i),
    .applied_height_o  (applied_height_o),
    .changed_o         (changed_o),
    .map_from_height_o (map_from_height_o),
    .redraw_low_o      (redraw_low_o),
    .redraw_high_o     (redraw_high_o),
    .top_height_o      (top_height_o)
  );

endmodule

### rtl/core/lzs_checker.sv
// Port checker for the layer stacking-order block, bound to the top level.
// Depends on layer_z_order_stack_assert.svh and lzs_pkg for widths.
`timescale 1ns / 1ps
`include "layer_z_order_stack_assert.svh"

module lzs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic        [lzs_pkg::ID_W-1:0]     layer_id_i,
  input logic signed [lzs_pkg::HEIGHT_W-1:0] new_height_i,
  input logic                                result_valid_o,
  input logic signed [lzs_pkg::HEIGHT_W-1:0] applied_height_o,
  input logic                                changed_o,
  input logic        [lzs_pkg::ID_W-1:0]     map_from_height_o,
  input logic        [lzs_pkg::ID_W-1:0]     redraw_low_o,
  input logic signed [lzs_pkg::HEIGHT_W-1:0] redraw_high_o,
  input logic signed [lzs_pkg::HEIGHT_W-1:0] top_height_o
);

  // A transfer makes the block busy once it is registered and yields its result after the read and apply steps.
  `LZS_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `LZS_ASSERT_NOW(a_result_latency, start && !busy, ##3 result_valid_o)
  `LZS_ASSERT_NOW(a_result_when_free, result_valid_o, !busy)
  `LZS_ASSERT_NOW(a_no_change_no_redraw, result_valid_o && !changed_o,
      (map_from_height_o == '0) && (redraw_low_o == '0) && (redraw_high_o == '1))

endmodule

bind layer_z_order_stack lzs_checker u_lzs_checker (.*);

### bench/layer_z_order_stack_check.sv
// Checker for the layer stacking-order block: watches the request and result ports,
// keeps its own copy of the stacking order and compares every result field.
// Depends on lzs_pkg for the field widths.
`timescale 1ns / 1ps

module layer_z_order_stack_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic        [lzs_pkg::ID_W-1:0]     layer_id_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] new_height_i,
  input  logic                                result_valid_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] applied_height_i,
  input  logic                                changed_i,
  input  logic        [lzs_pkg::ID_W-1:0]     map_from_height_i,
  input  logic        [lzs_pkg::ID_W-1:0]     redraw_low_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] redraw_high_i,
  input  logic signed [lzs_pkg::HEIGHT_W-1:0] top_height_i,
  output int unsigned                         due_count_o,
  output int unsigned                         mismatch_count_o
);

  typedef struct packed {
    logic [lzs_pkg::HEIGHT_W-1:0] applied;
    logic                         changed;
    logic [lzs_pkg::ID_W-1:0]     map_from;
    logic [lzs_pkg::ID_W-1:0]     redraw_low;
    logic [lzs_pkg::HEIGHT_W-1:0] redraw_high;
    logic [lzs_pkg::HEIGHT_W-1:0] top;
  } restack_t;

  logic [lzs_pkg::ID_W-1:0] layer_at [256];
  int                       height_of [256];
  int                       top_now;
  restack_t                 due_results [$];
  int unsigned              mismatches;

  function automatic void seat(input int h, input logic [lzs_pkg::ID_W-1:0] id);
    layer_at[8'(h)] = id;
    height_of[id]   = h;
  endfunction

  function automatic restack_t restack(input logic [lzs_pkg::ID_W-1:0] id,
                                       input logic signed [lzs_pkg::HEIGHT_W-1:0] req);
    int       h;
    int       old;
    int       t;
    int       tp;
    int       map_from;
    int       lo;
    int       hi;
    int       chg;
    restack_t r;
    h        = req;
    old      = height_of[id];
    tp       = top_now;
    map_from = 0;
    lo       = 0;
    hi       = -1;
    chg      = 0;
    if (old >= 0) begin
      if (h > tp) h = tp;
    end else if (h > tp + 1) begin
      h = tp + 1;
    end
    if (h < -1) h = -1;
    if (h < old) begin
      chg = 1;
      if (h >= 0) begin
        for (t = old; t > h; t--) seat(t, layer_at[8'(t - 1)]);
        seat(h, id);
        map_from = h + 1;
        lo       = h + 1;
        hi       = old;
      end else begin
        for (t = old; t < tp; t++) seat(t, layer_at[8'(t + 1)]);
        height_of[id] = -1;
        hi            = old - 1;
        tp--;
      end
    end else if (h > old) begin
      chg = 1;
      if (old >= 0) begin
        for (t = old; t < h; t++) seat(t, layer_at[8'(t + 1)]);
      end else begin
        for (t = tp; t >= h; t--) seat(t + 1, layer_at[8'(t)]);
        tp++;
      end
      seat(h, id);
      map_from = h;
      lo       = h;
      hi       = h;
    end
    top_now       = tp;
    r.applied     = 9'(h);
    r.changed     = 1'(chg);
    r.map_from    = 8'(map_from);
    r.redraw_low  = 8'(lo);
    r.redraw_high = 9'(hi);
    r.top         = 9'(tp);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    restack_t want;
    int       i;
    if (!rst_ni) begin
      for (i = 0; i < 256; i++) begin
        layer_at[i]  = '0;
        height_of[i] = -1;
      end
      top_now = -1;
      due_results.delete();
      mismatches = 0;
    end else begin
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual applied height %0d",
                   $time, applied_height_i);
        end else begin
          want = due_results.pop_front();
          check_field("applied_height", $signed(want.applied), applied_height_i);
          check_field("changed", want.changed, changed_i);
          check_field("map_from_height", want.map_from, map_from_height_i);
          check_field("redraw_low", want.redraw_low, redraw_low_i);
          check_field("redraw_high", $signed(want.redraw_high), redraw_high_i);
          check_field("top_height", $signed(want.top), top_height_i);
        end
      end
      if (start_i && !busy_i) due_results.push_back(restack(layer_id_i, new_height_i));
    end
    due_count_o      <= due_results.size();
    mismatch_count_o <= mismatches;
  end

endmodule

### bench/layer_z_order_stack_test.sv
// Top of the layer stacking-order test: clock, reset, request stimulus and verdict.
// Instantiates layer_z_order_stack and layer_z_order_stack_check; depends on lzs_pkg.
`timescale 1ns / 1ps

module layer_z_order_stack_test;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int PHASE_ITEMS    = 380;
  localparam int DIRECTED_ITEMS = 15;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic        [lzs_pkg::ID_W-1:0]     layer_id_i;
  logic signed [lzs_pkg::HEIGHT_W-1:0] new_height_i;
  logic                                result_valid_o;
  logic signed [lzs_pkg::HEIGHT_W-1:0] applied_height_o;
  logic                                changed_o;
  logic        [lzs_pkg::ID_W-1:0]     map_from_height_o;
  logic        [lzs_pkg::ID_W-1:0]     redraw_low_o;
  logic signed [lzs_pkg::HEIGHT_W-1:0] redraw_high_o;
  logic signed [lzs_pkg::HEIGHT_W-1:0] top_height_o;
  int unsigned                         due_count;
  int unsigned                         mismatch_count;
  int                                  stall_cycles = 0;

  // Insertions with clamping, raising past the top, hiding with clamping, lowering,
  // and requests that leave the height as it was.
  int directed_id [DIRECTED_ITEMS] = '{5, 0, 255, 10, 20, 10, 10, 0, 255, 7, 7, 3, 20,
                                       255, 3};
  int directed_h [DIRECTED_ITEMS]  = '{-1, 255, 255, 0, 1, 255, -256, -2, 0, 100, 255, 1,
                                       -1, 255, 0};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  layer_z_order_stack dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .layer_id_i       (layer_id_i),
    .new_height_i     (new_height_i),
    .result_valid_o   (result_valid_o),
    .applied_height_o (applied_height_o),
    .changed_o        (changed_o),
    .map_from_height_o(map_from_height_o),
    .redraw_low_o     (redraw_low_o),
    .redraw_high_o    (redraw_high_o),
    .top_height_o     (top_height_o)
  );

  layer_z_order_stack_check checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .layer_id_i       (layer_id_i),
    .new_height_i     (new_height_i),
    .result_valid_i   (result_valid_o),
    .applied_height_i (applied_height_o),
    .changed_i        (changed_o),
    .map_from_height_i(map_from_height_o),
    .redraw_low_i     (redraw_low_o),
    .redraw_high_i    (redraw_high_o),
    .top_height_i     (top_height_o),
    .due_count_o      (due_count),
    .mismatch_count_o (mismatch_count)
  );

  task automatic send(input logic [lzs_pkg::ID_W-1:0] id,
                      input logic signed [lzs_pkg::HEIGHT_W-1:0] h);
    start        <= 1'b1;
    layer_id_i   <= id;
    new_height_i <= h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_maybe(input int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 4);
      start        <= 1'b0;
      layer_id_i   <= 8'($urandom);
      new_height_i <= 9'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Most requests name a small set of layers and heights near the top, so that the
  // stack grows deep and layers are moved within it rather than only inserted.
  task automatic send_random(input int pct);
    logic [lzs_pkg::ID_W-1:0]            id;
    logic signed [lzs_pkg::HEIGHT_W-1:0] h;
    int                                  r;
    r = $urandom_range(0, 99);
    if (r < 60) id = 8'($urandom_range(0, 15));
    else if (r < 90) id = 8'($urandom_range(0, 63));
    else id = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) h = -9'sd1;
    else if (r < 30) h = 9'($urandom);
    else h = 9'(int'($urandom_range(0, 48)) - 1);
    send(id, h);
    pause_maybe(pct);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("layer_z_order_stack test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int p;
    int i;
    int pct;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    layer_id_i   <= '0;
    new_height_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < DIRECTED_ITEMS; i++) begin
      send(8'(directed_id[i]), 9'(directed_h[i]));
      pause_maybe(11);
    end
    for (p = 0; p < 3; p++) begin
      pct = (p == 0) ? 11 : (p == 1) ? 73 : 0;
      repeat (PHASE_ITEMS) send_random(pct);
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("layer_z_order_stack test passed");
    end else begin
      $display("layer_z_order_stack test failed");
    end
    $finish;
  end

endmodule
